>>> hdl/calendar_mjd_gps_time_converter_core_macros.svh
// assertion macros for the calendar / mjd / gps time converter
`ifndef CALENDAR_MJD_GPS_TIME_CONVERTER_CORE_MACROS_SVH
`define CALENDAR_MJD_GPS_TIME_CONVERTER_CORE_MACROS_SVH

// implication checked every cycle outside reset
`define CMGT_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("cmgt assertion failed");

// next-cycle implication that also holds across reset
`define CMGT_ASSERT_NXT(lbl, clk_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) (ante) |=> (cons)) \
    else $error("cmgt reset assertion failed");

`endif

>>> hdl/cmgt_pkg.sv
// shared types, codes and constants of the time converter
`default_nettype none
package cmgt_pkg;

  // time systems
  localparam logic [1:0] SYS_CAL = 2'd0;
  localparam logic [1:0] SYS_MJD = 2'd1;
  localparam logic [1:0] SYS_GPS = 2'd2;

  // operation codes
  localparam logic [2:0] OP_CAL_MJD = 3'd0;
  localparam logic [2:0] OP_MJD_CAL = 3'd1;
  localparam logic [2:0] OP_GPS_MJD = 3'd2;
  localparam logic [2:0] OP_MJD_GPS = 3'd3;
  localparam logic [2:0] OP_CAL_GPS = 3'd4;
  localparam logic [2:0] OP_GPS_CAL = 3'd5;

  localparam logic [39:0] US_DAY  = 40'd86400000000;
  localparam logic [39:0] US_HOUR = 40'd3600000000;
  localparam logic [39:0] US_MIN  = 40'd60000000;

  // working context of one transaction
  typedef struct packed {
    logic               bad;
    logic [1:0]         src;
    logic [1:0]         dst;
    logic signed [12:0] yr;
    logic [3:0]         mo;
    logic [4:0]         dy;
    logic [4:0]         hr;
    logic [5:0]         mi;
    logic [25:0]        sec;
    logic [39:0]        tval;
    logic signed [22:0] dval;
    logic [3:0]         q;
    logic [25:0]        aux;
    logic [39:0]        prod;
    logic [13:0]        cq;
    logic [3:0]         e;
    logic [4:0]         hq;
    logic [5:0]         mq;
  } ctx_t;

  // floor(30.6001 * k)
  function automatic logic [8:0] mon_tab(input logic [4:0] k);
    logic [8:0] v;
    begin
      case (k)
        5'd1:    v = 9'd30;
        5'd2:    v = 9'd61;
        5'd3:    v = 9'd91;
        5'd4:    v = 9'd122;
        5'd5:    v = 9'd153;
        5'd6:    v = 9'd183;
        5'd7:    v = 9'd214;
        5'd8:    v = 9'd244;
        5'd9:    v = 9'd275;
        5'd10:   v = 9'd306;
        5'd11:   v = 9'd336;
        5'd12:   v = 9'd367;
        5'd13:   v = 9'd397;
        5'd14:   v = 9'd428;
        5'd15:   v = 9'd459;
        5'd16:   v = 9'd489;
        default: v = 9'd0;
      endcase
      return v;
    end
  endfunction

endpackage
`default_nettype wire

>>> hdl/cmgt_front.sv
// front end: decodes the operation, checks input validity, builds the context
`default_nettype none
module cmgt_front (
  input  wire logic [2:0]  op,
  input  wire logic [11:0] year,
  input  wire logic [3:0]  month,
  input  wire logic [4:0]  day,
  input  wire logic [4:0]  hour,
  input  wire logic [5:0]  minute,
  input  wire logic [25:0] second_us,
  input  wire logic [16:0] mjd_days,
  input  wire logic [36:0] day_us,
  input  wire logic [12:0] gps_week,
  input  wire logic [39:0] week_us,
  output cmgt_pkg::ctx_t   item
);
  import cmgt_pkg::*;

  logic date_zero;
  logic mjd_zero;
  logic gps_zero;

  assign date_zero = (month == 4'd0) || (day == 5'd0);
  assign mjd_zero  = (mjd_days == 17'd0) && (day_us == 37'd0);
  assign gps_zero  = (gps_week == 13'd0) && (week_us == 40'd0);

  always_comb begin
    item = '0;
    unique case (op)
      OP_CAL_MJD: begin
        item.src = SYS_CAL; item.dst = SYS_MJD; item.bad = date_zero;
      end
      OP_MJD_CAL: begin
        item.src = SYS_MJD; item.dst = SYS_CAL; item.bad = mjd_zero;
      end
      OP_GPS_MJD: begin
        item.src = SYS_GPS; item.dst = SYS_MJD; item.bad = gps_zero;
      end
      OP_MJD_GPS: begin
        item.src = SYS_MJD; item.dst = SYS_GPS; item.bad = mjd_zero;
      end
      OP_CAL_GPS: begin
        item.src = SYS_CAL; item.dst = SYS_GPS; item.bad = date_zero;
      end
      OP_GPS_CAL: begin
        item.src = SYS_GPS; item.dst = SYS_CAL; item.bad = gps_zero;
      end
      default: begin
        item.src = SYS_MJD; item.dst = SYS_MJD; item.bad = 1'b1;
      end
    endcase
    // january and february count as months 13 and 14 of the previous year
    if (month <= 4'd2) begin
      item.yr = 13'({1'b0, year} - 13'd1);
      item.mo = month + 4'd12;
    end else begin
      item.yr = 13'({1'b0, year});
      item.mo = month;
    end
    item.dy  = day;
    item.hr  = hour;
    item.mi  = minute;
    item.sec = second_us;
    if (item.src == SYS_MJD) begin
      item.tval = 40'(day_us);
      item.dval = 23'(mjd_days);
    end else if (item.src == SYS_GPS) begin
      item.tval = week_us;
      item.cq   = 14'(gps_week);
    end
  end

endmodule
`default_nettype wire

>>> hdl/cmgt_queue.sv
// short fifo between front end and back end
`default_nettype none
module cmgt_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  cmgt_pkg::ctx_t  push_data,
  input  wire logic       pop,
  output logic            full,
  output logic            not_empty,
  output cmgt_pkg::ctx_t  head
);
  import cmgt_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ctx_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/cmgt_back.sv
// back end: conversion pipeline and output register
`default_nettype none
module cmgt_back (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        head_valid,
  input  cmgt_pkg::ctx_t   head,
  output logic             head_pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             ok,
  output logic [11:0]      out_year,
  output logic [3:0]       out_month,
  output logic [4:0]       out_day,
  output logic [4:0]       out_hour,
  output logic [5:0]       out_minute,
  output logic [25:0]      out_second_us,
  output logic [16:0]      out_mjd_days,
  output logic [36:0]      out_day_us,
  output logic [12:0]      out_gps_week,
  output logic [39:0]      out_week_us
);
  import cmgt_pkg::*;

  localparam int NST = 18;

  function automatic ctx_t step(input int s, input ctx_t ci);
    ctx_t               c;
    logic signed [24:0] a_s;
    logic signed [22:0] nd;
    logic [39:0]        wt;
    logic [25:0]        kd;
    logic [3:0]         m;
    int                 cnt;
    begin
      c   = ci;
      a_s = '0;
      nd  = '0;
      wt  = '0;
      kd  = (c.dst == SYS_GPS) ? 26'd7 : 26'd7305;
      m   = '0;
      cnt = 0;
      case (s) inside
        0: begin
          if (c.src == SYS_CAL) begin
            c.tval = 40'(c.hr) * US_HOUR + 40'(c.mi) * US_MIN + 40'(c.sec);
            a_s    = 25'(c.yr) * 25'sd1461;
            c.dval = 23'(a_s >>> 2);
            c.aux  = 26'(mon_tab(5'(c.mo) + 5'd1)) + 26'(c.dy);
          end else if (c.src == SYS_GPS) begin
            c.dval = 23'd44244 + 23'(c.cq) * 23'd7;
          end
        end
        1: begin
          if (c.src == SYS_CAL) begin
            c.dval = c.dval + 23'(c.aux) - 23'd679019;
          end
        end
        [2:5]: begin
          // whole days out of the time value, one quotient bit a stage
          wt = US_DAY << (5 - s);
          if (c.tval >= wt) begin
            c.tval = c.tval - wt;
            c.q    = c.q | (4'd1 << (5 - s));
          end
        end
        6: begin
          nd     = c.dval + 23'(c.q);
          c.dval = nd;
          if (c.src == SYS_CAL && (nd < 23'sd0 || nd > 23'sd131071)) begin
            c.bad = 1'b1;
          end
          if (c.dst == SYS_GPS && nd < 23'sd44244) begin
            c.bad = 1'b1;
          end
        end
        7: begin
          if (c.dst == SYS_GPS) begin
            c.aux = 26'(c.dval - 23'sd44244);
          end else begin
            c.aux = 26'(c.dval) * 26'd20 + 26'd48028318;
          end
        end
        8: begin
          // reciprocal of 7 or 7305
          if (c.dst == SYS_GPS) begin
            c.prod = 40'(c.aux) * 40'd18724;
          end else begin
            c.prod = 40'(c.aux) * 40'd9186;
          end
        end
        9: begin
          if (c.dst == SYS_GPS) begin
            c.cq = 14'(c.prod >> 17);
          end else begin
            c.cq = 14'(c.prod >> 26);
          end
        end
        10: begin
          c.aux = c.aux - 26'(c.cq) * kd;
        end
        11: begin
          // estimate is at most one low
          if (c.aux >= kd) begin
            c.cq  = c.cq + 14'd1;
            c.aux = c.aux - kd;
          end
        end
        12: begin
          if (c.dst == SYS_GPS) begin
            if (c.cq > 14'd8191) begin
              c.bad = 1'b1;
            end
            c.tval = 40'(c.aux[2:0]) * US_DAY + c.tval;
          end else begin
            c.prod = (40'(c.cq) * 40'd1461) >> 2;
          end
        end
        13: begin
          c.aux = 26'(c.dval) + 26'd2401538 - 26'(c.prod);
        end
        14: begin
          for (int k = 1; k <= 15; k++) begin
            if (c.aux > 26'(mon_tab(5'(k)))) begin
              cnt = cnt + 1;
            end
          end
          c.e = 4'(cnt);
        end
        15: begin
          c.dy = 5'(c.aux - 26'(mon_tab(5'(c.e))));
          m    = (c.e >= 4'd14) ? c.e - 4'd13 : c.e - 4'd1;
          c.mo = m;
          c.yr = 13'(c.cq - 14'd4715 - 14'(m >= 4'd3));
        end
        default: begin
        end
      endcase
      // time of day: hours in stages 7 to 11, minutes in stages 12 to 17
      if (c.dst == SYS_CAL && s >= 7 && s <= 11) begin
        wt = US_HOUR << (11 - s);
        if (c.tval >= wt) begin
          c.tval = c.tval - wt;
          c.hq   = c.hq | (5'd1 << (11 - s));
        end
      end
      if (c.dst == SYS_CAL && s >= 12 && s <= 17) begin
        wt = US_MIN << (17 - s);
        if (c.tval >= wt) begin
          c.tval = c.tval - wt;
          c.mq   = c.mq | (6'd1 << (17 - s));
        end
      end
      return c;
    end
  endfunction

  ctx_t         pipe [1:NST];
  logic [NST:1] pv;
  logic         adv;
  ctx_t         f;

  assign adv      = !out_valid || out_ready;
  assign head_pop = head_valid && adv;
  assign f        = pipe[NST];

  always_ff @(posedge clk) begin
    if (adv) begin
      pipe[1] <= step(0, head);
      for (int g = 1; g < NST; g++) begin
        pipe[g+1] <= step(g, pipe[g]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= '0;
    end else if (adv) begin
      pv <= {pv[NST-1:1], head_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= pv[NST];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ok            <= !f.bad;
      out_year      <= '0;
      out_month     <= '0;
      out_day       <= '0;
      out_hour      <= '0;
      out_minute    <= '0;
      out_second_us <= '0;
      out_mjd_days  <= '0;
      out_day_us    <= '0;
      out_gps_week  <= '0;
      out_week_us   <= '0;
      if (!f.bad) begin
        if (f.dst == SYS_CAL) begin
          out_year      <= f.yr[11:0];
          out_month     <= f.mo;
          out_day       <= f.dy;
          out_hour      <= f.hq;
          out_minute    <= f.mq;
          out_second_us <= f.tval[25:0];
        end else if (f.dst == SYS_MJD) begin
          out_mjd_days  <= f.dval[16:0];
          out_day_us    <= f.tval[36:0];
        end else begin
          out_gps_week  <= f.cq[12:0];
          out_week_us   <= f.tval;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/calendar_mjd_gps_time_converter_core.sv
// top level of the calendar / mjd / gps time converter
//
//  channel   direction  handshake              payload
//  input     in         in_valid / in_ready    op, date, time, mjd, gps fields
//  output    out        out_valid / out_ready  ok and converted fields
//
// one transaction per cycle sustained while the output is not stalled; an accepted
// transaction passes the queue write, 18 pipeline stages and the output register
// the pipeline length is set by the digit-by-digit day, hour and minute division stages
// rst is synchronous active high and empties the queue and the pipeline
// a stalled output freezes the whole pipeline; the input keeps taking
// transactions until the queue of QUEUE_DEPTH entries is full
`default_nettype none
`include "calendar_mjd_gps_time_converter_core_macros.svh"
module calendar_mjd_gps_time_converter_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  op,
  input  wire logic [11:0] year,
  input  wire logic [3:0]  month,
  input  wire logic [4:0]  day,
  input  wire logic [4:0]  hour,
  input  wire logic [5:0]  minute,
  input  wire logic [25:0] second_us,
  input  wire logic [16:0] mjd_days,
  input  wire logic [36:0] day_us,
  input  wire logic [12:0] gps_week,
  input  wire logic [39:0] week_us,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             ok,
  output logic [11:0]      out_year,
  output logic [3:0]       out_month,
  output logic [4:0]       out_day,
  output logic [4:0]       out_hour,
  output logic [5:0]       out_minute,
  output logic [25:0]      out_second_us,
  output logic [16:0]      out_mjd_days,
  output logic [36:0]      out_day_us,
  output logic [12:0]      out_gps_week,
  output logic [39:0]      out_week_us
);
  import cmgt_pkg::*;

  ctx_t item;       // classified transaction from the front end
  ctx_t head;       // oldest queued transaction
  logic q_full;
  logic q_valid;
  logic q_pop;
  logic push;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  // decode and validity checks, no state
  cmgt_front u_front (
    .op        (op),
    .year      (year),
    .month     (month),
    .day       (day),
    .hour      (hour),
    .minute    (minute),
    .second_us (second_us),
    .mjd_days  (mjd_days),
    .day_us    (day_us),
    .gps_week  (gps_week),
    .week_us   (week_us),
    .item      (item)
  );

  // decouples input acceptance from pipeline stalls
  cmgt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (item),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (head)
  );

  // day carry, date arithmetic, gps week split, time of day
  cmgt_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (q_valid),
    .head          (head),
    .head_pop      (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .ok            (ok),
    .out_year      (out_year),
    .out_month     (out_month),
    .out_day       (out_day),
    .out_hour      (out_hour),
    .out_minute    (out_minute),
    .out_second_us (out_second_us),
    .out_mjd_days  (out_mjd_days),
    .out_day_us    (out_day_us),
    .out_gps_week  (out_gps_week),
    .out_week_us   (out_week_us)
  );

  // rejected transactions carry all-zero fields
  `CMGT_ASSERT_IMP(a_reject_zero, clk, rst, out_valid && !ok,
    out_year == 12'd0 && out_mjd_days == 17'd0 && out_week_us == 40'd0 && out_day == 5'd0)
  // a calendar result is a real date and time of day
  `CMGT_ASSERT_IMP(a_cal_range, clk, rst, out_valid && ok && out_month != 4'd0,
    out_day != 5'd0 && out_month <= 4'd12 && out_hour < 5'd24 && out_minute < 6'd60)
  // day and week fractions stay below their period
  `CMGT_ASSERT_IMP(a_frac_range, clk, rst, out_valid && ok,
    out_day_us < 37'd86400000000 && out_week_us < 40'd604800000000)
  // reset leaves an empty pipeline and an open input
  `CMGT_ASSERT_NXT(a_reset_clear, clk, rst, !out_valid && in_ready)

endmodule
`default_nettype wire
